@@ hw/rtl/ptbs_pkg.sv @@
// ---------------------------------------------------------------------------
// ptbs_pkg
// shared types and constants of the perspective bilinear texture sampler
// ---------------------------------------------------------------------------
package ptbs_pkg;

  // field widths
  localparam int CoordW  = 31;  // u/z, v/z, 1/z
  localparam int ColorW  = 24;  // packed rgb texel
  localparam int ChanW   = 8;   // one color channel
  localparam int TaddrW  = 16;  // texel address field
  localparam int CfgW    = 9;   // widest configuration register

  // divider shape: dividend is coordinate << 14, remainder stays below 1/z
  localparam int FracShift = 14;
  localparam int QuoW      = CoordW + FracShift;  // 45 quotient bits
  localparam int RemW      = CoordW;
  localparam int WeightW   = 17;                  // up to 256 * 256

  // register indexes of the configuration port
  localparam logic RegTextureSize = 1'b0;
  localparam logic RegRowPitch    = 1'b1;

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindPixel = 1'b1;

  // side data carried along the divider
  typedef struct packed {
    logic              kind;
    logic [TaddrW-1:0] taddr;
    logic [ColorW-1:0] color;
    logic [ChanW-1:0]  shade_r;
    logic [ChanW-1:0]  shade_g;
    logic [ChanW-1:0]  shade_b;
  } pay_t;

endpackage

@@ hw/rtl/ptbs_ram.sv @@
// ---------------------------------------------------------------------------
// ptbs_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module ptbs_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [0:Depth-1];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/perspective_bilinear_texture_sampler_top.sv @@
// ---------------------------------------------------------------------------
// perspective_bilinear_texture_sampler_top
// perspective-correct bilinear texture sampler with shade modulation
// ---------------------------------------------------------------------------
// One input channel (in_valid_i / in_stall_o) takes texel writes (kind 0)
// and pixel samples (kind 1). Each pixel word gives one output word on
// out_valid_o / out_stall_i; a texel write gives none.
// Throughput: one word per cycle while the output is not stalled, writes and pixels mixed.
// A pixel passes through one input register, 45 one-bit restoring divide
// steps (u and v side by side), coordinate clamp, address multiply,
// texture memory read, bilinear blend and shade multiply. The divider
// length sets the latency.
// Texel writes go to memory at the same stage where pixels read, so every
// pixel sees exactly the writes that came before it.
// The texture store is four copies of TexelDepth x 24 bits (one per corner
// of the 2x2 footprint); TexelDepth is a power of two. Entries are not
// cleared: never read one that was not written.
// Reset clears all valid bits and sets both size registers to 256.
// An output stall while out_valid_o is high freezes the whole pipeline
// and raises in_stall_o in the same cycle; nothing is lost or repeated.
// The user writes configuration only while idle; the block does not check.
// ---------------------------------------------------------------------------
module perspective_bilinear_texture_sampler_top #(
  parameter int TexelDepth = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] texel_address_i,
  input  logic [23:0] texel_color_i,
  input  logic [30:0] u_over_z_i,
  input  logic [30:0] v_over_z_i,
  input  logic [30:0] inv_z_i,
  input  logic [7:0]  shade_red_i,
  input  logic [7:0]  shade_green_i,
  input  logic [7:0]  shade_blue_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);

  localparam int AddrW  = $clog2(TexelDepth);
  localparam int SumW   = 18;  // row * pitch + column
  localparam int FullW  = (AddrW > SumW) ? AddrW : SumW;
  localparam int Steps  = ptbs_pkg::QuoW;
  localparam int QW     = ptbs_pkg::QuoW;
  localparam int RW     = ptbs_pkg::RemW;
  localparam int WW     = ptbs_pkg::WeightW;
  localparam int CW     = ptbs_pkg::ChanW;

  // global pipeline advance
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // configuration registers
  logic [8:0] cfg_size_q, cfg_pitch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q  <= 9'd256;
      cfg_pitch_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ptbs_pkg::RegTextureSize) cfg_size_q <= cfg_data_i;
      if (cfg_idx_i == ptbs_pkg::RegRowPitch)    cfg_pitch_q <= cfg_data_i;
    end
  end

  // divider pipeline storage, stage 0 is the input register
  logic            d_vld_q [0:Steps];
  ptbs_pkg::pay_t  d_pay_q [0:Steps];
  logic [RW-1:0]   d_iz_q  [0:Steps];
  logic [QW-1:0]   d_nu_q  [0:Steps];
  logic [QW-1:0]   d_nv_q  [0:Steps];
  logic [RW-1:0]   d_ru_q  [0:Steps];
  logic [RW-1:0]   d_rv_q  [0:Steps];
  logic [QW-1:0]   d_qu_q  [0:Steps];
  logic [QW-1:0]   d_qv_q  [0:Steps];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q[0] <= 1'b0;
    end else if (adv) begin
      d_vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_pay_q[0] <= '{kind: kind_i, taddr: texel_address_i, color: texel_color_i,
                      shade_r: shade_red_i, shade_g: shade_green_i,
                      shade_b: shade_blue_i};
      d_iz_q[0]  <= (inv_z_i == '0) ? RW'(1) : inv_z_i;
      d_nu_q[0]  <= {u_over_z_i, ptbs_pkg::FracShift'(0)};
      d_nv_q[0]  <= {v_over_z_i, ptbs_pkg::FracShift'(0)};
      d_ru_q[0]  <= '0;
      d_rv_q[0]  <= '0;
      d_qu_q[0]  <= '0;
      d_qv_q[0]  <= '0;
    end
  end

  // restoring divide, one quotient bit per stage for u and v
  for (genvar j = 0; j < Steps; j++) begin : g_div
    logic [RW:0] tu, tv;
    logic        geu, gev;

    assign tu  = {d_ru_q[j], d_nu_q[j][QW-1]};
    assign tv  = {d_rv_q[j], d_nv_q[j][QW-1]};
    assign geu = tu >= {1'b0, d_iz_q[j]};
    assign gev = tv >= {1'b0, d_iz_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        d_vld_q[j+1] <= d_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_pay_q[j+1] <= d_pay_q[j];
        d_iz_q[j+1]  <= d_iz_q[j];
        d_nu_q[j+1]  <= {d_nu_q[j][QW-2:0], 1'b0};
        d_nv_q[j+1]  <= {d_nv_q[j][QW-2:0], 1'b0};
        d_ru_q[j+1]  <= geu ? RW'(tu - {1'b0, d_iz_q[j]}) : tu[RW-1:0];
        d_rv_q[j+1]  <= gev ? RW'(tv - {1'b0, d_iz_q[j]}) : tv[RW-1:0];
        d_qu_q[j+1]  <= {d_qu_q[j][QW-2:0], geu};
        d_qv_q[j+1]  <= {d_qv_q[j][QW-2:0], gev};
      end
    end
  end

  // effective texture size, 1..256
  logic [8:0] size_eff;
  logic [7:0] size_m1;
  always_comb begin
    if (cfg_size_q == '0)          size_eff = 9'd1;
    else if (cfg_size_q > 9'd256)  size_eff = 9'd256;
    else                           size_eff = cfg_size_q;
  end
  assign size_m1 = 8'(size_eff - 9'd1);

  // coordinate clamp and edge neighbors
  logic [QW-9:0] qu_hi, qv_hi;
  logic [7:0]    x0_d, y0_d, x1_d, y1_d;
  assign qu_hi = d_qu_q[Steps][QW-1:8];
  assign qv_hi = d_qv_q[Steps][QW-1:8];
  always_comb begin
    x0_d = (qu_hi >= (QW-8)'(size_eff)) ? size_m1 : qu_hi[7:0];
    y0_d = (qv_hi >= (QW-8)'(size_eff)) ? size_m1 : qv_hi[7:0];
    x1_d = ((9'(x0_d) + 9'd1) >= size_eff) ? x0_d : 8'(x0_d + 8'd1);
    y1_d = ((9'(y0_d) + 9'd1) >= size_eff) ? y0_d : 8'(y0_d + 8'd1);
  end

  logic           a_vld_q;
  ptbs_pkg::pay_t a_pay_q;
  logic [7:0]     a_x0_q, a_y0_q, a_x1_q, a_y1_q, a_fu_q, a_fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= d_vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pay_q <= d_pay_q[Steps];
      a_x0_q  <= x0_d;
      a_y0_q  <= y0_d;
      a_x1_q  <= x1_d;
      a_y1_q  <= y1_d;
      a_fu_q  <= d_qu_q[Steps][7:0];
      a_fv_q  <= d_qv_q[Steps][7:0];
    end
  end

  // texel addresses and bilinear weights
  logic [16:0]      row0_off, row1_off;
  logic [FullW-1:0] s00, s10, s01, s11, sw;
  logic [8:0]       iu, iv;
  logic [17:0]      w00_d, w10_d, w01_d, w11_d;

  assign row0_off = 17'(a_y0_q) * 17'(cfg_pitch_q);
  assign row1_off = 17'(a_y1_q) * 17'(cfg_pitch_q);
  assign s00 = FullW'(row0_off) + FullW'(a_x0_q);
  assign s10 = FullW'(row0_off) + FullW'(a_x1_q);
  assign s01 = FullW'(row1_off) + FullW'(a_x0_q);
  assign s11 = FullW'(row1_off) + FullW'(a_x1_q);
  assign sw  = FullW'(a_pay_q.taddr);
  assign iu  = 9'd256 - 9'(a_fu_q);
  assign iv  = 9'd256 - 9'(a_fv_q);
  assign w00_d = 18'(iu) * 18'(iv);
  assign w10_d = 18'(a_fu_q) * 18'(iv);
  assign w01_d = 18'(iu) * 18'(a_fv_q);
  assign w11_d = 18'(a_fu_q) * 18'(a_fv_q);

  logic             b_vld_q;
  ptbs_pkg::pay_t   b_pay_q;
  logic [AddrW-1:0] b_a00_q, b_a10_q, b_a01_q, b_a11_q, b_wa_q;
  logic [WW-1:0]    b_w00_q, b_w10_q, b_w01_q, b_w11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pay_q <= a_pay_q;
      b_a00_q <= s00[AddrW-1:0];
      b_a10_q <= s10[AddrW-1:0];
      b_a01_q <= s01[AddrW-1:0];
      b_a11_q <= s11[AddrW-1:0];
      b_wa_q  <= sw[AddrW-1:0];
      b_w00_q <= w00_d[WW-1:0];
      b_w10_q <= w10_d[WW-1:0];
      b_w01_q <= w01_d[WW-1:0];
      b_w11_q <= w11_d[WW-1:0];
    end
  end

  // texture store, one copy per footprint corner, written in item order
  logic        tex_we;
  logic [23:0] t00, t10, t01, t11;
  assign tex_we = adv && b_vld_q && (b_pay_q.kind == ptbs_pkg::KindWrite);

  ptbs_ram #(.Width(ptbs_pkg::ColorW), .Depth(TexelDepth)) u_ram00 (
    .clk_i, .we_i(tex_we), .waddr_i(b_wa_q), .wdata_i(b_pay_q.color),
    .re_i(adv), .raddr_i(b_a00_q), .rdata_o(t00)
  );
  ptbs_ram #(.Width(ptbs_pkg::ColorW), .Depth(TexelDepth)) u_ram10 (
    .clk_i, .we_i(tex_we), .waddr_i(b_wa_q), .wdata_i(b_pay_q.color),
    .re_i(adv), .raddr_i(b_a10_q), .rdata_o(t10)
  );
  ptbs_ram #(.Width(ptbs_pkg::ColorW), .Depth(TexelDepth)) u_ram01 (
    .clk_i, .we_i(tex_we), .waddr_i(b_wa_q), .wdata_i(b_pay_q.color),
    .re_i(adv), .raddr_i(b_a01_q), .rdata_o(t01)
  );
  ptbs_ram #(.Width(ptbs_pkg::ColorW), .Depth(TexelDepth)) u_ram11 (
    .clk_i, .we_i(tex_we), .waddr_i(b_wa_q), .wdata_i(b_pay_q.color),
    .re_i(adv), .raddr_i(b_a11_q), .rdata_o(t11)
  );

  logic           c_vld_q;
  ptbs_pkg::pay_t c_pay_q;
  logic [WW-1:0]  c_w00_q, c_w10_q, c_w01_q, c_w11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_pay_q <= b_pay_q;
      c_w00_q <= b_w00_q;
      c_w10_q <= b_w10_q;
      c_w01_q <= b_w01_q;
      c_w11_q <= b_w11_q;
    end
  end

  // bilinear blend per channel, channel 0 red, 1 green, 2 blue
  logic [CW-1:0] blend_d [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_blend
    localparam int Lo = 16 - 8 * k;
    logic [25:0] sum;
    assign sum = 26'(c_w00_q) * 26'(t00[Lo +: CW]) + 26'(c_w10_q) * 26'(t10[Lo +: CW])
               + 26'(c_w01_q) * 26'(t01[Lo +: CW]) + 26'(c_w11_q) * 26'(t11[Lo +: CW]);
    assign blend_d[k] = sum[23:16];
  end

  logic          e_vld_q;
  logic [CW-1:0] e_r_q, e_g_q, e_b_q, e_sr_q, e_sg_q, e_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= c_vld_q && (c_pay_q.kind == ptbs_pkg::KindPixel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_r_q  <= blend_d[0];
      e_g_q  <= blend_d[1];
      e_b_q  <= blend_d[2];
      e_sr_q <= c_pay_q.shade_r;
      e_sg_q <= c_pay_q.shade_g;
      e_sb_q <= c_pay_q.shade_b;
    end
  end

  // shade modulation into the output register
  logic [15:0] mr, mg, mb;
  logic [CW-1:0] out_r_q, out_g_q, out_b_q;
  assign mr = 16'(e_r_q) * 16'(e_sr_q);
  assign mg = 16'(e_g_q) * 16'(e_sg_q);
  assign mb = 16'(e_b_q) * 16'(e_sb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_r_q <= mr[15:8];
      out_g_q <= mg[15:8];
      out_b_q <= mb[15:8];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_r_q;
  assign out_green_o = out_g_q;
  assign out_blue_o  = out_b_q;

  // checks on the datapath
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q[Steps] |-> (d_ru_q[Steps] < d_iz_q[Steps]) && (d_rv_q[Steps] < d_iz_q[Steps]))
    else $error("divider remainder not below divisor");

  a_coord_in_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q |-> (9'(a_x1_q) < size_eff) && (9'(a_y1_q) < size_eff)
                && (a_x1_q >= a_x0_q) && (a_y1_q >= a_y0_q))
    else $error("texel coordinate outside texture");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && c_vld_q && (c_pay_q.kind == ptbs_pkg::KindWrite)) |=> !e_vld_q)
    else $error("texel write produced a result");

endmodule

@@ sim/tb_perspective_bilinear_texture_sampler_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_perspective_bilinear_texture_sampler_top
// self-checking bench for the perspective bilinear texture sampler
// ---------------------------------------------------------------------------
// Runs the block through several texture size / row pitch settings. Phase
// 0 sends a few directed pixels; each phase sends random texel writes and
// pixel samples; before any pixel, every texel of its 2x2 footprint that
// was never written is written first. Accepted words are predicted in the
// bench and compared against the output words in order. Both sides idle at
// random in most phases, and once the output holds off to back up the input.
// ---------------------------------------------------------------------------
module tb_perspective_bilinear_texture_sampler_top;

  localparam int TexDepth  = 65536;
  localparam int Latency   = 60;
  localparam int StallMax  = 17;
  localparam int WatchMax  = 3000;
  localparam int NumPhases = 8;
  localparam int RandomPerPhase = 100;
  localparam longint CoordMax = 64'h7FFF_FFFF;

  typedef struct {
    logic                        kind;
    logic [ptbs_pkg::TaddrW-1:0] taddr;
    logic [ptbs_pkg::ColorW-1:0] color;
    logic [ptbs_pkg::CoordW-1:0] uz;
    logic [ptbs_pkg::CoordW-1:0] vz;
    logic [ptbs_pkg::CoordW-1:0] iz;
    logic [ptbs_pkg::ChanW-1:0]  sr;
    logic [ptbs_pkg::ChanW-1:0]  sg;
    logic [ptbs_pkg::ChanW-1:0]  sb;
  } word_t;

  typedef struct {
    logic [ptbs_pkg::ChanW-1:0] r;
    logic [ptbs_pkg::ChanW-1:0] g;
    logic [ptbs_pkg::ChanW-1:0] b;
  } rgb_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = ptbs_pkg::RegTextureSize;
  logic [8:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = ptbs_pkg::KindWrite;
  logic [15:0] texel_address_i = '0;
  logic [23:0] texel_color_i = '0;
  logic [30:0] u_over_z_i = '0;
  logic [30:0] v_over_z_i = '0;
  logic [30:0] inv_z_i = '0;
  logic [7:0] shade_red_i = '0;
  logic [7:0] shade_green_i = '0;
  logic [7:0] shade_blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;

  perspective_bilinear_texture_sampler_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // bench state
  word_t pending_words[$];
  rgb_t  expected_pixels[$];
  logic [ptbs_pkg::ColorW-1:0] texel_mirror [TexDepth];
  bit    texel_planned [TexDepth];
  int unsigned tex_size = 256;
  int unsigned tex_pitch = 256;
  bit    idle_on = 1'b1;
  int    errors = 0;
  int    words_in = 0;
  int    pixels_out = 0;
  int    sender_gap = 0;
  int    receiver_gap = 0;
  int    long_hold = 0;
  bit    long_hold_done = 1'b0;
  int    quiet_cycles = 0;

  function automatic int unsigned eff_size();
    if (tex_size == 0) return 1;
    if (tex_size > 256) return 256;
    return tex_size;
  endfunction

  // perspective divide, clamp and edge neighbours of one pixel
  function automatic void locate_footprint(input logic [ptbs_pkg::CoordW-1:0] uz, vz, iz,
      output int unsigned x0, y0, x1, y1, fu, fv);
    longint unsigned div, qu, qv;
    int unsigned sz;
    sz = eff_size();
    div = (iz == 0) ? 1 : iz;
    qu = (longint'(uz) << ptbs_pkg::FracShift) / div;
    qv = (longint'(vz) << ptbs_pkg::FracShift) / div;
    fu = 32'(qu & 8'hFF);
    fv = 32'(qv & 8'hFF);
    x0 = ((qu >> 8) >= sz) ? sz - 1 : 32'(qu >> 8);
    y0 = ((qv >> 8) >= sz) ? sz - 1 : 32'(qv >> 8);
    x1 = (x0 + 1 >= sz) ? x0 : x0 + 1;
    y1 = (y0 + 1 >= sz) ? y0 : y0 + 1;
  endfunction

  function automatic int unsigned texel_addr(int unsigned row, col);
    return (row * tex_pitch + col) % TexDepth;
  endfunction

  // filtered and shaded color of one pixel word
  function automatic rgb_t shade_filtered(word_t w);
    int unsigned x0, y0, x1, y1, fu, fv, w00, w10, w01, w11, f, sh;
    logic [ptbs_pkg::ColorW-1:0] t00, t10, t01, t11;
    int unsigned chans[3];
    int unsigned shades[3];
    rgb_t res;
    locate_footprint(w.uz, w.vz, w.iz, x0, y0, x1, y1, fu, fv);
    t00 = texel_mirror[texel_addr(y0, x0)];
    t10 = texel_mirror[texel_addr(y0, x1)];
    t01 = texel_mirror[texel_addr(y1, x0)];
    t11 = texel_mirror[texel_addr(y1, x1)];
    w00 = (256 - fu) * (256 - fv);
    w10 = fu * (256 - fv);
    w01 = (256 - fu) * fv;
    w11 = fu * fv;
    shades[0] = w.sr;
    shades[1] = w.sg;
    shades[2] = w.sb;
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      f = (w00 * t00[sh +: 8] + w10 * t10[sh +: 8] + w01 * t01[sh +: 8] +
           w11 * t11[sh +: 8]) >> 16;
      chans[k] = ((f * shades[k]) >> 8) & 8'hFF;
    end
    res.r = 8'(chans[0]);
    res.g = 8'(chans[1]);
    res.b = 8'(chans[2]);
    return res;
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.kind = 1'($urandom_range(0, 1));
    w.taddr = 16'($urandom);
    w.color = 24'($urandom);
    w.uz = 31'($urandom);
    w.vz = 31'($urandom);
    w.iz = 31'($urandom);
    w.sr = 8'($urandom);
    w.sg = 8'($urandom);
    w.sb = 8'($urandom);
    return w;
  endfunction

  task automatic queue_write(input int unsigned addr,
      input logic [ptbs_pkg::ColorW-1:0] color);
    word_t w;
    w = random_word();
    w.kind = ptbs_pkg::KindWrite;
    w.taddr = 16'(addr);
    w.color = color;
    texel_planned[addr] = 1'b1;
    pending_words.push_back(w);
  endtask

  // a pixel word, preceded by writes to any footprint texel not yet written
  task automatic queue_pixel(input logic [ptbs_pkg::CoordW-1:0] uz, vz, iz,
      input logic [ptbs_pkg::ChanW-1:0] sr, sg, sb);
    int unsigned x0, y0, x1, y1, fu, fv;
    int unsigned addrs[4];
    word_t w;
    locate_footprint(uz, vz, iz, x0, y0, x1, y1, fu, fv);
    addrs[0] = texel_addr(y0, x0);
    addrs[1] = texel_addr(y0, x1);
    addrs[2] = texel_addr(y1, x0);
    addrs[3] = texel_addr(y1, x1);
    foreach (addrs[i])
      if (!texel_planned[addrs[i]]) queue_write(addrs[i], 24'($urandom));
    w = random_word();
    w.kind = ptbs_pkg::KindPixel;
    w.uz = uz;
    w.vz = vz;
    w.iz = iz;
    w.sr = sr;
    w.sg = sg;
    w.sb = sb;
    pending_words.push_back(w);
  endtask

  // coordinate aimed at the texture, or anywhere
  function automatic logic [ptbs_pkg::CoordW-1:0] aim_coord(
      input logic [ptbs_pkg::CoordW-1:0] iz);
    longint unsigned tgt, c;
    if ($urandom_range(0, 4) == 0) return 31'($urandom);
    tgt = $urandom_range(0, eff_size() * 256 + 300);
    c = (tgt * longint'(iz == 0 ? 1 : iz)) >> ptbs_pkg::FracShift;
    c += $urandom_range(0, 3);
    return (c > CoordMax) ? 31'(CoordMax) : 31'(c);
  endfunction

  task automatic queue_random(input int count);
    logic [ptbs_pkg::CoordW-1:0] iz;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_write($urandom_range(0, TexDepth - 1), 24'($urandom));
      end else begin
        iz = 31'($urandom & ((32'd1 << $urandom_range(1, 31)) - 1));
        if ($urandom_range(0, 9) == 0) iz = 0;
        queue_pixel(aim_coord(iz), aim_coord(iz), iz,
                    8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ptbs_pkg::RegTextureSize) tex_size = value;
    else tex_pitch = value;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d (pixel %0d)", what, got, want, pixels_out);
    errors++;
  endtask

  // stimulus and phases
  initial begin
    int unsigned sizes[NumPhases] = '{256, 1, 16, 256, 0, 5, 400, 37};
    int unsigned pitches[NumPhases] = '{256, 1, 17, 1, 0, 300, 256, 100};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p != 0) begin
        write_reg(ptbs_pkg::RegTextureSize, 9'(sizes[p]));
        write_reg(ptbs_pkg::RegRowPitch, 9'(pitches[p]));
      end
      for (int a = 0; a < TexDepth; a++) texel_planned[a] = 1'b0;
      idle_on = (p % 3 != 2);
      if (p == 0) begin
        // store extremes, clamped coordinates, zero and full shade
        queue_write(16'hFFFF, 24'hFFFFFF);
        queue_write(16'h0000, 24'h000000);
        queue_pixel(31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(31'd0, 31'd0, 31'h7FFFFFFF, 8'h00, 8'h00, 8'h00);
        queue_pixel(31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 8'hFF, 8'h00, 8'h80);
        queue_pixel(31'd0, 31'h7FFFFFFF, 31'd0, 8'h01, 8'hFF, 8'h7F);
        queue_pixel(31'd8388800, 31'd4194368, 31'd268435456, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(31'd1069547520, 31'd1069547520, 31'h7FFFFFFF, 8'hFF, 8'hAA, 8'h55);
        queue_pixel(31'd16384, 31'd16383, 31'd16384, 8'hFF, 8'hFF, 8'hFF);
        queue_write(16'h8000, 24'h800000);
      end
      queue_random(RandomPerPhase);
    end
    drain();
    $display("covered %0d accepted words and %0d checked pixels over %0d settings",
             words_in, pixels_out, NumPhases);
    $display("settings included size 0, 1 and over 256, and row pitch 0 and 300");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // sender: accept at rising edge, drive at falling edge
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      words_in++;
      if (pending_words[0].kind == ptbs_pkg::KindWrite) begin
        texel_mirror[pending_words[0].taddr] = pending_words[0].color;
      end else begin
        expected_pixels.push_back(shade_filtered(pending_words[0]));
      end
      void'(pending_words.pop_front());
      sender_gap = idle_on ? $urandom_range(0, StallMax) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (sender_gap > 0) begin
      sender_gap--;
      in_valid_i <= 1'b0;
    end else if (rst_ni && pending_words.size() != 0) begin
      in_valid_i <= 1'b1;
      kind_i <= pending_words[0].kind;
      texel_address_i <= pending_words[0].taddr;
      texel_color_i <= pending_words[0].color;
      u_over_z_i <= pending_words[0].uz;
      v_over_z_i <= pending_words[0].vz;
      inv_z_i <= pending_words[0].iz;
      shade_red_i <= pending_words[0].sr;
      shade_green_i <= pending_words[0].sg;
      shade_blue_i <= pending_words[0].sb;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: check at rising edge, stall at falling edge
  always @(posedge clk_i) begin
    rgb_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("unexpected output word: %0d %0d %0d", out_red_o, out_green_o, out_blue_o);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_red_o !== want.r) report_mismatch("red", out_red_o, want.r);
        if (out_green_o !== want.g) report_mismatch("green", out_green_o, want.g);
        if (out_blue_o !== want.b) report_mismatch("blue", out_blue_o, want.b);
      end
      pixels_out++;
      receiver_gap = idle_on ? $urandom_range(0, StallMax) : 0;
      if (pixels_out == 150 && !long_hold_done) begin
        long_hold = 400;
        long_hold_done = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (long_hold > 0) begin
      long_hold--;
      out_stall_i <= 1'b1;
    end else if (receiver_gap > 0) begin
      receiver_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no accept on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchMax) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
